// ===== sv/bufr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bufr_pkg;

    localparam logic [7:0] BYTE_START = 8'h00;
    localparam logic [7:0] BYTE_END   = 8'h01;
    localparam logic [7:0] BYTE_ESC   = 8'h1b;

    typedef enum logic
    {
        CMD_WRITE = 1'b0,
        CMD_CLOSE = 1'b1
    } cmd_op_t;

    typedef struct packed
    {
        cmd_op_t    op;
        logic [7:0] data;
    } cmd_t;

endpackage
`default_nettype wire

// ===== sv/bufr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bufr_front
    import bufr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       rx_valid,
    output logic            rx_stall,
    input  wire logic [7:0] rx_byte,
    output logic            push,
    output cmd_t            push_cmd,
    input  wire logic       full
);

    typedef enum logic [2:0]
    {
        M_IDLE   = 3'b001,
        M_FRAME  = 3'b010,
        M_ESCAPE = 3'b100
    } mode_t;

    mode_t mode_reg;
    mode_t mode_next;
    logic  accept;

    assign rx_stall = full;
    assign accept   = rx_valid && !full;

    // Classify the byte: data bytes and the close go to the back end.
    always_comb
    begin
        mode_next     = mode_reg;
        push          = 1'b0;
        push_cmd.op   = CMD_WRITE;
        push_cmd.data = rx_byte;
        if (accept)
        begin
            case (mode_reg)
                M_FRAME:
                begin
                    if (rx_byte == BYTE_ESC)
                    begin
                        mode_next = M_ESCAPE;
                    end
                    else if (rx_byte == BYTE_END)
                    begin
                        push        = 1'b1;
                        push_cmd.op = CMD_CLOSE;
                        mode_next   = M_IDLE;
                    end
                    else if (rx_byte != BYTE_START)
                    begin
                        push = 1'b1;
                    end
                end
                M_ESCAPE:
                begin
                    push      = 1'b1;
                    mode_next = M_FRAME;
                end
                default:
                begin
                    if (rx_byte == BYTE_START)
                    begin
                        mode_next = M_FRAME;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/bufr_cmd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bufr_cmd_fifo
    import bufr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    output logic      valid,
    input  wire logic pop,
    output cmd_t      pop_cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full    = (count_reg == 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("command pushed into a full queue");

endmodule
`default_nettype wire

// ===== sv/bufr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bufr_back
    import bufr_pkg::*;
#(
    parameter int MSG_LEN = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    output logic            pop,
    input  wire cmd_t       cmd,
    output logic            msg_valid,
    input  wire logic       msg_stall,
    output logic [7:0]      msg_byte,
    output logic [3:0]      byte_index,
    output logic            last,
    output logic            overflow
);

    localparam int AW = (MSG_LEN > 1) ? $clog2(MSG_LEN) : 1;
    localparam int CW = $clog2(MSG_LEN + 1);

    typedef enum logic [2:0]
    {
        B_IDLE = 3'b001,
        B_READ = 3'b010,
        B_LOAD = 3'b100
    } back_state_t;

    back_state_t   state_reg;
    back_state_t   state_next;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [7:0]    out_byte_reg;
    logic [3:0]    out_index_reg;
    logic          out_last_reg;
    logic          out_ovf_reg;
    logic [7:0]    rd_data_reg;
    logic [7:0]    mem [MSG_LEN];

    logic          out_free;
    logic          load;
    logic          last_pos;
    logic          has_room;
    logic          wr_en;

    assign out_free = !out_valid_reg || !msg_stall;
    assign load     = (state_reg == B_LOAD) && out_free;
    assign last_pos = (idx_reg == AW'(MSG_LEN - 1));
    assign has_room = (fill_reg < CW'(MSG_LEN));
    assign pop      = q_valid && (state_reg == B_IDLE);
    assign wr_en    = pop && (cmd.op == CMD_WRITE) && has_room;

    assign msg_valid  = out_valid_reg;
    assign msg_byte   = out_byte_reg;
    assign byte_index = out_index_reg;
    assign last       = out_last_reg;
    assign overflow   = out_ovf_reg;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && msg_stall;
        case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    if (cmd.op == CMD_CLOSE)
                    begin
                        idx_next   = '0;
                        state_next = B_READ;
                    end
                    else if (has_room)
                    begin
                        fill_next = fill_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            B_READ:
            begin
                state_next = B_LOAD;
            end
            B_LOAD:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    if (last_pos)
                    begin
                        fill_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = B_READ;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Positions at or past the fill count go out as zero padding.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg  <= (CW'(idx_reg) < fill_reg) ? rd_data_reg : 8'h00;
            out_index_reg <= 4'(idx_reg);
            out_last_reg  <= last_pos;
            out_ovf_reg   <= ovf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[fill_reg[AW-1:0]] <= cmd.data;
        end
        rd_data_reg <= mem[idx_reg];
    end

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(MSG_LEN))
        else $error("fill count beyond message length");

    a_ovf_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (fill_reg == CW'(MSG_LEN)))
        else $error("overflow flagged before the store is full");

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (load && last_pos) |=> (fill_reg == '0) && !ovf_reg && out_last_reg)
        else $error("frame state not cleared after final byte");

endmodule
`default_nettype wire

// ===== sv/byte_unstuffing_frame_receiver_core.sv =====
// Byte-unstuffing frame receiver with fixed-length message output.
// Receive channel: rx_valid / rx_stall / rx_byte, one raw serial byte per
// transaction. A 0x00 opens a frame, 0x1b escapes the next byte, 0x01 closes
// the frame; bare 0x00 inside a frame and any byte outside a frame are dropped.
// Message channel: msg_valid / msg_stall with msg_byte, byte_index, last and
// overflow. Each close yields exactly MSG_LEN transactions, stored bytes first
// and zero padding after, last set on the final one and overflow set on all of
// them when the frame carried more than MSG_LEN data bytes.
// Throughput: the front end takes one byte per cycle into a two-entry command
// queue unless it is full; the back end retires one data byte per cycle while
// idle and emits each message byte by a memory read, then an output register
// load, taking no command meanwhile. A close byte passes the queue and the read
// and load states before the first message byte is valid. rx_stall rises only
// while the queue is full, which happens while a message is going out and two
// more commands are waiting. A stall on msg_stall holds the output register and
// freezes emission; the front end keeps taking bytes until the queue fills.
// Reset (rst_n low, asynchronous) returns to idle with an empty queue, a zero
// fill count and a clear overflow flag; the message store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module byte_unstuffing_frame_receiver_core
    import bufr_pkg::*;
#(
    parameter int MSG_LEN = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       rx_valid,
    output logic            rx_stall,
    input  wire logic [7:0] rx_byte,
    output logic            msg_valid,
    input  wire logic       msg_stall,
    output logic [7:0]      msg_byte,
    output logic [3:0]      byte_index,
    output logic            last,
    output logic            overflow
);

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    // Front end: track framing mode, turn bytes into write/close commands.
    bufr_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .rx_byte  (rx_byte),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full)
    );

    // Hold commands so the front keeps receiving while a message drains.
    bufr_cmd_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .valid    (q_valid),
        .pop      (q_pop),
        .pop_cmd  (q_cmd)
    );

    // Back end: store data bytes, count them, emit the message on close.
    bufr_back #(
        .MSG_LEN (MSG_LEN)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .pop        (q_pop),
        .cmd        (q_cmd),
        .msg_valid  (msg_valid),
        .msg_stall  (msg_stall),
        .msg_byte   (msg_byte),
        .byte_index (byte_index),
        .last       (last),
        .overflow   (overflow)
    );

endmodule
`default_nettype wire

// ===== tb/sv/tb_byte_unstuffing_frame_receiver_core.sv =====
`timescale 1ns / 1ps

// Testbench for the byte-unstuffing frame receiver.
//
// Raw bytes go in on the rx channel; the message channel returns exactly
// MSG_LEN transactions per closed frame. A behavioral model of the receiver
// runs on every accepted rx transaction and queues the message it expects.
// Every accepted message transaction is then compared against the oldest
// queued entry.
//
// Both channels idle at random. Gaps on the rx side and stalls on the message
// side are mostly short with an occasional long one, and some stretches run
// with no idling at all.

module tb_byte_unstuffing_frame_receiver_core;

    import bufr_pkg::*;

    localparam int MSG_LEN        = 16;
    localparam int RANDOM_ITEMS   = 400;
    localparam int DRAIN_CYCLES   = 8;     // idle time after the last expected byte, to catch extras
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction on either side

    typedef enum logic [1:0]
    {
        RX_IDLE   = 2'd0,
        RX_FRAME  = 2'd1,
        RX_ESCAPE = 2'd2
    } rx_mode_t;

    typedef struct
    {
        logic [7:0] msg_byte;
        logic [3:0] byte_index;
        logic       last;
        logic       overflow;
    } msg_beat_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       rx_valid;
    logic       rx_stall;
    logic [7:0] rx_byte;
    logic       msg_valid;
    logic       msg_stall = 1'b0;
    logic [7:0] msg_byte;
    logic [3:0] byte_index;
    logic       last;
    logic       overflow;

    // Receiver model state
    rx_mode_t   frame_mode;
    int         frame_fill;
    logic [7:0] frame_bytes [MSG_LEN];
    logic       frame_overflow;

    msg_beat_t  expected_msgs [$];
    int         fail_count   = 0;
    int         quiet_cycles = 0;
    int         stall_hold   = 0;
    bit         gaps_on      = 1'b1;
    bit         stalls_on    = 1'b1;

    byte_unstuffing_frame_receiver_core #(
        .MSG_LEN (MSG_LEN)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .rx_byte    (rx_byte),
        .msg_valid  (msg_valid),
        .msg_stall  (msg_stall),
        .msg_byte   (msg_byte),
        .byte_index (byte_index),
        .last       (last),
        .overflow   (overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle length: mostly zero, sometimes a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Data byte that carries no framing meaning.
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == BYTE_START || b == BYTE_END || b == BYTE_ESC);
        return b;
    endfunction

    // Store one data byte, or drop it and flag overflow once the frame is full.
    function automatic void keep_data(input logic [7:0] b);
        if (frame_fill < MSG_LEN)
        begin
            frame_bytes[frame_fill] = b;
            frame_fill++;
        end
        else
        begin
            frame_overflow = 1'b1;
        end
    endfunction

    // Advance the receiver model by one accepted rx byte. A close queues
    // MSG_LEN message beats: stored bytes first, then zero padding.
    function automatic void unstuff_byte(input logic [7:0] b);
        msg_beat_t beat;
        case (frame_mode)
            RX_FRAME:
            begin
                if (b == BYTE_ESC)
                begin
                    frame_mode = RX_ESCAPE;
                end
                else if (b == BYTE_END)
                begin
                    for (int k = 0; k < MSG_LEN; k++)
                    begin
                        beat.msg_byte   = (k < frame_fill) ? frame_bytes[k] : 8'h00;
                        beat.byte_index = 4'(k);
                        beat.last       = (k == MSG_LEN - 1);
                        beat.overflow   = frame_overflow;
                        expected_msgs.push_back(beat);
                    end
                    frame_mode     = RX_IDLE;
                    frame_fill     = 0;
                    frame_overflow = 1'b0;
                end
                else if (b != BYTE_START)
                begin
                    keep_data(b);
                end
                // a bare start byte inside a frame is dropped
            end
            RX_ESCAPE:
            begin
                keep_data(b);
                frame_mode = RX_FRAME;
            end
            default:
            begin
                if (b == BYTE_START)
                    frame_mode = RX_FRAME;
            end
        endcase
    endfunction

    // Monitor: feed the model with each accepted rx transaction, then check
    // each accepted message transaction. Both use values sampled at the edge.
    always @(posedge clk)
    begin
        msg_beat_t want;
        if (rst_n)
        begin
            if (rx_valid && !rx_stall)
                unstuff_byte(rx_byte);

            if (msg_valid && !msg_stall)
            begin
                if (expected_msgs.size() == 0)
                begin
                    $error("unexpected message byte %02h at index %0d", msg_byte, byte_index);
                    fail_count++;
                end
                else
                begin
                    want = expected_msgs.pop_front();
                    if (msg_byte !== want.msg_byte)
                    begin
                        $error("msg_byte: expected %02h, got %02h", want.msg_byte, msg_byte);
                        fail_count++;
                    end
                    if (byte_index !== want.byte_index)
                    begin
                        $error("byte_index: expected %0d, got %0d",
                               want.byte_index, byte_index);
                        fail_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %b, got %b", want.last, last);
                        fail_count++;
                    end
                    if (overflow !== want.overflow)
                    begin
                        $error("overflow: expected %b, got %b", want.overflow, overflow);
                        fail_count++;
                    end
                end
            end

            if ((rx_valid && !rx_stall) || (msg_valid && !msg_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stall the message channel in bursts; hold it low while stalls are off.
    always @(posedge clk)
    begin
        if (!rst_n || !stalls_on)
        begin
            stall_hold = 0;
            msg_stall <= 1'b0;
        end
        else if (stall_hold > 0)
        begin
            stall_hold--;
            msg_stall <= 1'b1;
        end
        else
        begin
            msg_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                stall_hold = pick_gap();
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    initial
    begin
        wait (rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    // Send one raw byte and hold it until the transaction completes. Drop
    // valid only when a gap follows, so back-to-back sends keep it high.
    task automatic send_rx(input logic [7:0] b);
        int gap;
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (rx_stall);
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Bytes outside a frame, including the close and escape codes, are dropped.
    task automatic test_idle_bytes();
        send_rx(BYTE_END);
        send_rx(BYTE_ESC);
        send_rx(8'hff);
    endtask

    // An empty frame yields a message of padding only.
    task automatic test_empty_frame();
        send_rx(BYTE_START);
        send_rx(BYTE_END);
    endtask

    // Escaped framing codes are stored literally, a bare start inside the
    // frame is dropped, and an escaped byte past a full frame sets overflow.
    task automatic test_escape_and_overflow();
        send_rx(BYTE_START);
        send_rx(BYTE_ESC);
        send_rx(BYTE_START);
        send_rx(BYTE_START);
        send_rx(BYTE_ESC);
        send_rx(BYTE_END);
        send_rx(BYTE_ESC);
        send_rx(BYTE_ESC);
        send_rx(8'h7f);
        send_rx(8'h80);
        for (int i = 5; i < MSG_LEN; i++)
            send_rx(plain_byte());
        send_rx(BYTE_ESC);
        send_rx(8'h55);
        send_rx(BYTE_END);
    endtask

    // Well-formed frames with random content and length up to eight bytes past
    // the message length, almost half at or past it, mixed with line noise and stray start bytes.
    task automatic test_random_frames(input int target);
        int sent;
        int len;
        int r;
        sent = 0;
        while (sent < target)
        begin
            gaps_on   = ($urandom_range(0, 4) != 0);
            stalls_on = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 3))
                begin
                    send_rx(8'($urandom_range(1, 255)));
                    sent++;
                end

            r = $urandom_range(0, 99);
            if (r < 45)
                len = $urandom_range(1, MSG_LEN - 1);
            else if (r < 70)
                len = MSG_LEN;
            else if (r < 90)
                len = $urandom_range(MSG_LEN + 1, MSG_LEN + 8);
            else
                len = 0;

            send_rx(BYTE_START);
            sent++;
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    send_rx(BYTE_START);
                    sent++;
                end
                if ($urandom_range(0, 4) == 0)
                begin
                    send_rx(BYTE_ESC);
                    send_rx(8'($urandom_range(0, 255)));
                    sent += 2;
                end
                else
                begin
                    send_rx(plain_byte());
                    sent++;
                end
            end
            send_rx(BYTE_END);
            sent++;
        end
    endtask

    initial
    begin
        frame_mode     = RX_IDLE;
        frame_fill     = 0;
        frame_overflow = 1'b0;
        rst_n    <= 1'b0;
        rx_valid <= 1'b0;
        rx_byte  <= 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_bytes();
        test_empty_frame();
        test_escape_and_overflow();
        test_random_frames(RANDOM_ITEMS);

        // Drain: let every expected message byte arrive, then idle a little
        // longer to catch anything extra.
        rx_valid <= 1'b0;
        @(posedge clk);
        while (expected_msgs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
